>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lpcm_pkg.sv
// ----------------------------------------------------------------------------
// lpcm_pkg
// shared types, codes and rounding helpers of the lpcm sample decoder
// ----------------------------------------------------------------------------
package lpcm_pkg;

  // sample size codes, reserved code acts as 24 bits
  localparam logic [1:0] SIZE_16 = 2'd0;
  localparam logic [1:0] SIZE_20 = 2'd1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_ORDER    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

  typedef struct packed {
    logic [1:0] sample_size;
    logic       msb_first;
    logic [3:0] channel_count;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [2:0]         chan;
    logic               fend;
  } result_t;

  // one or two results caused by a single input word
  typedef struct packed {
    result_t first;
    result_t second;
    logic    pair;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // last channel index, out of range counts clamp to 1..8
  function automatic logic [2:0] last_chan(input logic [3:0] n);
    if (n == 4'd0) begin
      return 3'd0;
    end else if (n > 4'd8) begin
      return 3'd7;
    end else begin
      return 3'(n - 4'd1);
    end
  endfunction

  function automatic logic signed [15:0] sat17(input logic signed [16:0] v);
    if (v > 17'sd32767) begin
      return 16'sh7fff;
    end else if (v < -17'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  // (v + 128) >>> 8 then clamp
  function automatic logic signed [15:0] round24(input logic [23:0] raw);
    logic signed [24:0] s;
    s = $signed({raw[23], raw}) + 25'sd128;
    return sat17(s[24:8]);
  endfunction

  // (v + 8) >>> 4 then clamp
  function automatic logic signed [15:0] round20(input logic [19:0] raw);
    logic signed [20:0] s;
    s = $signed({raw[19], raw}) + 21'sd8;
    return sat17(s[20:4]);
  endfunction

endpackage

>>> rtl/core/lpcm_in_if.sv
// ----------------------------------------------------------------------------
// lpcm_in_if
// input byte channel: valid/ready handshake with one payload byte
// ----------------------------------------------------------------------------
interface lpcm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_start;

  modport source (output valid, output data_byte, output buffer_start, input ready);
  modport sink (input valid, input data_byte, input buffer_start, output ready);
endinterface

>>> rtl/core/lpcm_out_if.sv
// ----------------------------------------------------------------------------
// lpcm_out_if
// result channel: valid/ready handshake with one decoded sample
// ----------------------------------------------------------------------------
interface lpcm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  logic [2:0]         channel_index;
  logic               frame_end;
  logic               run_last;

  modport source (
    output valid, output sample_out, output channel_index, output frame_end,
    output run_last, input ready
  );
  modport sink (
    input valid, input sample_out, input channel_index, input frame_end,
    input run_last, output ready
  );
endinterface

>>> rtl/core/lpcm_outq.sv
// ----------------------------------------------------------------------------
// lpcm_outq
// two-entry result queue, unloads a pair bundle as two words
// ----------------------------------------------------------------------------
module lpcm_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lpcm_pkg::bundle_t  bundle,
  output lpcm_pkg::q_stat_t  stat,
  lpcm_out_if.source         out_ch
);

  lpcm_pkg::bundle_t q_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       sub_r, sub_nxt;

  lpcm_pkg::bundle_t head;
  lpcm_pkg::result_t cur;
  logic last, pop, retire;

  always_comb begin
    head = q_r[rd_r];
    cur  = sub_r ? head.second : head.first;
    last = !head.pair || sub_r;

    out_ch.valid         = (cnt_r != 2'd0);
    out_ch.sample_out    = cur.sample;
    out_ch.channel_index = cur.chan;
    out_ch.frame_end     = cur.fend;
    out_ch.run_last      = last;

    pop    = out_ch.valid && out_ch.ready;
    retire = pop && last;

    sub_nxt = retire ? 1'b0 : (pop ? 1'b1 : sub_r);
    wr_nxt  = push ? !wr_r : wr_r;
    rd_nxt  = retire ? !rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, retire};

    stat.full  = (cnt_r == 2'd2);
    stat.empty = (cnt_r == 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
      sub_r <= 1'b0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
      sub_r <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= bundle;
    end
  end

endmodule

>>> rtl/core/lpcm_unpack.sv
// ----------------------------------------------------------------------------
// lpcm_unpack
// byte assembly, rounding and channel tracking for one accepted byte
// ----------------------------------------------------------------------------
module lpcm_unpack (
  input  logic              clk,
  input  logic              rst_n,
  input  lpcm_pkg::cfg_t    cfg,
  input  logic              acc,
  input  logic [7:0]        data_byte,
  input  logic              buffer_start,
  output logic              push,
  output lpcm_pkg::bundle_t bundle
);

  logic [2:0] phase_r, phase_nxt;
  logic [2:0] chan_r, chan_nxt;
  logic [7:0] held_r [4];

  logic [2:0] ph, ch, ch1, ch2, lastph, lc;
  logic       complete, fe0, fe1, is16, is20;
  logic [7:0] h0, h1, h2, h3;
  logic [19:0] x20, y20;
  logic [23:0] v24;
  logic signed [15:0] s0;

  always_comb begin
    ph = buffer_start ? 3'd0 : phase_r;
    ch = buffer_start ? 3'd0 : chan_r;
    h0 = held_r[0];
    h1 = held_r[1];
    h2 = held_r[2];
    h3 = held_r[3];

    is16 = 1'b0;
    is20 = 1'b0;
    case (cfg.sample_size)
      lpcm_pkg::SIZE_16: begin
        lastph = 3'd1;
        is16   = 1'b1;
      end
      lpcm_pkg::SIZE_20: begin
        lastph = 3'd4;
        is20   = 1'b1;
      end
      default: lastph = 3'd2;
    endcase
    complete  = (ph >= lastph);
    phase_nxt = complete ? 3'd0 : 3'(ph + 3'd1);

    if (cfg.msb_first) begin
      x20 = {h0, h1, data_byte[7:4]};
      y20 = {h2, h3, data_byte[3:0]};
      v24 = {h0, h1, data_byte};
    end else begin
      x20 = {h1, h0, data_byte[3:0]};
      y20 = {h3, h2, data_byte[7:4]};
      v24 = {data_byte, h1, h0};
    end

    if (is16) begin
      s0 = cfg.msb_first ? $signed({h0, data_byte}) : $signed({data_byte, h0});
    end else if (is20) begin
      s0 = lpcm_pkg::round20(x20);
    end else begin
      s0 = lpcm_pkg::round24(v24);
    end

    // channel of each result, a counter at or past the last channel wraps
    lc  = lpcm_pkg::last_chan(cfg.channel_count);
    fe0 = (ch >= lc);
    ch1 = fe0 ? 3'd0 : 3'(ch + 3'd1);
    fe1 = (ch1 >= lc);
    ch2 = fe1 ? 3'd0 : 3'(ch1 + 3'd1);
    if (!complete) begin
      chan_nxt = ch;
    end else if (is20) begin
      chan_nxt = ch2;
    end else begin
      chan_nxt = ch1;
    end

    bundle.first.sample  = s0;
    bundle.first.chan    = ch;
    bundle.first.fend    = fe0;
    bundle.second.sample = lpcm_pkg::round20(y20);
    bundle.second.chan   = ch1;
    bundle.second.fend   = fe1;
    bundle.pair          = is20;
    push                 = acc && complete;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 3'd0;
      chan_r  <= 3'd0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      chan_r  <= chan_nxt;
    end
  end

  // phase is below four whenever the byte is held
  always_ff @(posedge clk) begin
    if (acc && !complete) begin
      held_r[ph[1:0]] <= data_byte;
    end
  end

endmodule

>>> rtl/core/lpcm_to_s16_sample_decoder.sv
// ----------------------------------------------------------------------------
// lpcm_to_s16_sample_decoder
// packed disc lpcm bytes in, rounded and clamped signed 16-bit samples out
// ----------------------------------------------------------------------------
// usage:
//   in_ch takes one payload byte per word; buffer_start restarts byte phase
//   and channel count at that byte. out_ch gives one sample per word with
//   its channel index, end of frame mark and run_last on the final sample
//   caused by a byte. a 20-bit pair gives two words on its fifth byte.
//   cfg_we/cfg_index/cfg_wdata write sample size, byte order and channel
//   count; write them only while no sample is pending.
// timing:
//   a byte is taken every cycle while the result queue has room; into an
//   empty queue a sample appears on out_ch the cycle after its last byte
//   is taken. assembly and rounding are combinational between the state
//   registers and a two-entry result queue, which sets the byte rate.
// reset:
//   rst_n clears phase, channel counter and queue and loads the default
//   configuration (16 bits, big-endian, two channels).
// stall:
//   while out_ch.ready is low the queue holds up to two result bundles;
//   in_ch.ready drops only when it is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpcm_to_s16_sample_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lpcm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lpcm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  lpcm_in_if.sink                           in_ch,
  lpcm_out_if.source                        out_ch
);

  lpcm_pkg::cfg_t    cfg_r;
  lpcm_pkg::bundle_t bundle;
  lpcm_pkg::q_stat_t qs;
  logic              acc, push;
  logic              pair_first, chan_at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_size   <= lpcm_pkg::SIZE_16;
      cfg_r.msb_first     <= 1'b1;
      cfg_r.channel_count <= 4'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpcm_pkg::CFG_SAMPLE_SIZE:   cfg_r.sample_size   <= cfg_wdata[1:0];
        lpcm_pkg::CFG_BYTE_ORDER:    cfg_r.msb_first     <= cfg_wdata[0];
        lpcm_pkg::CFG_CHANNEL_COUNT: cfg_r.channel_count <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !qs.full;
  assign acc         = in_ch.valid && in_ch.ready;

  lpcm_unpack u_unpack (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .acc          (acc),
    .data_byte    (in_ch.data_byte),
    .buffer_start (in_ch.buffer_start),
    .push         (push),
    .bundle       (bundle)
  );

  lpcm_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .bundle (bundle),
    .stat   (qs),
    .out_ch (out_ch)
  );

  assign pair_first  = out_ch.valid && out_ch.ready && !out_ch.run_last;
  assign chan_at_end = (out_ch.channel_index >= lpcm_pkg::last_chan(cfg_r.channel_count));

  // second sample of a pair follows right after the first is taken
  `ASSERT_NEXT(a_pair_second, pair_first, out_ch.valid && out_ch.run_last, "second sample missing")

  // an empty queue always takes input
  `ASSERT_SAME(a_empty_ready, !out_ch.valid, in_ch.ready, "input stalled with empty queue")

  // frame end marks the last channel of the current count
  `ASSERT_SAME(a_frame_end, out_ch.valid, out_ch.frame_end == chan_at_end, "frame end mismatch")

endmodule

>>> sim/lpcm_to_s16_sample_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcm_to_s16_sample_decoder_tb
// self-checking bench for the lpcm byte to signed 16-bit sample decoder.
// bytes are queued by the test tasks and offered at the falling edge; every
// accepted byte runs through a local decoder that predicts the samples, and
// each sample taken from out_ch is compared against the oldest prediction.
// covers all sample sizes and byte orders, rounding and clamping, channel
// count clamping, format changes mid-sample and mid-frame, buffer restarts
// and output back-pressure.
// ----------------------------------------------------------------------------
module lpcm_to_s16_sample_decoder_tb;

  localparam logic [1:0] SIZE_24       = 2'd2;
  localparam logic [1:0] SIZE_RESERVED = 2'd3;
  localparam logic       ORDER_BIG     = 1'b1;
  localparam logic       ORDER_LITTLE  = 1'b0;
  localparam int         STALL_LIMIT   = 2000;
  localparam int         REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } lpcm_byte_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [2:0]         chan;
    logic               fend;
    logic               last;
  } sample_word_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [lpcm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [lpcm_pkg::CFG_DATA_W-1:0] cfg_wdata;

  lpcm_in_if  in_ch ();
  lpcm_out_if out_ch ();

  lpcm_to_s16_sample_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #4 clk = ~clk;

  lpcm_byte_t   pending_bytes[$];
  sample_word_t expected_samples[$];
  int bytes_queued      = 0;
  int bytes_taken       = 0;
  int samples_predicted = 0;
  int samples_checked   = 0;
  int error_count       = 0;
  int send_idle_pct     = 0;
  int recv_idle_pct     = 0;
  int hold_request      = 0;
  int hold_left         = 0;
  int stall_cycles      = 0;
  bit offer_live        = 1'b0;

  // decoder state mirrored by the bench
  logic [1:0] size_q;
  logic       endian_q;
  logic [3:0] chans_q;
  logic [2:0] phase_q;
  logic [7:0] held_q [4];
  logic [2:0] chan_q;

  function automatic logic signed [15:0] round_to_s16(input int value, input int drop);
    int r;
    r = (value + (1 << (drop - 1))) >>> drop;
    if (r > 32767) begin
      r = 32767;
    end else if (r < -32768) begin
      r = -32768;
    end
    return 16'(r);
  endfunction

  function automatic void queue_sample(input logic signed [15:0] value, input logic last);
    sample_word_t w;
    int n;
    n = int'(chans_q);
    if (n == 0) begin
      n = 1;
    end
    if (n > 8) begin
      n = 8;
    end
    w.sample = value;
    w.chan   = chan_q;
    w.fend   = (int'(chan_q) >= n - 1);
    w.last   = last;
    expected_samples.push_back(w);
    samples_predicted++;
    chan_q = w.fend ? 3'd0 : chan_q + 3'd1;
  endfunction

  function automatic void decode_lpcm_byte(input logic [7:0] b, input logic start);
    int last_phase;
    logic [15:0] w16;
    logic [19:0] hi;
    logic [19:0] lo;
    logic [23:0] w24;
    if (start) begin
      phase_q = 3'd0;
      chan_q  = 3'd0;
    end
    if (size_q == lpcm_pkg::SIZE_16) begin
      last_phase = 1;
    end else if (size_q == lpcm_pkg::SIZE_20) begin
      last_phase = 4;
    end else begin
      last_phase = 2;
    end
    if (int'(phase_q) < last_phase) begin
      held_q[phase_q[1:0]] = b;
      phase_q = phase_q + 3'd1;
      return;
    end
    phase_q = 3'd0;
    if (size_q == lpcm_pkg::SIZE_16) begin
      w16 = endian_q ? {held_q[0], b} : {b, held_q[0]};
      queue_sample(w16, 1'b1);
    end else if (size_q == lpcm_pkg::SIZE_20) begin
      // fifth byte carries both low nibbles, order depends on endianness
      if (endian_q) begin
        hi = {held_q[0], held_q[1], b[7:4]};
        lo = {held_q[2], held_q[3], b[3:0]};
      end else begin
        hi = {held_q[1], held_q[0], b[3:0]};
        lo = {held_q[3], held_q[2], b[7:4]};
      end
      queue_sample(round_to_s16(int'($signed(hi)), 4), 1'b0);
      queue_sample(round_to_s16(int'($signed(lo)), 4), 1'b1);
    end else begin
      w24 = endian_q ? {held_q[0], held_q[1], b} : {b, held_q[1], held_q[0]};
      queue_sample(round_to_s16(int'($signed(w24)), 8), 1'b1);
    end
  endfunction

  task automatic log_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // byte driver: a word once offered stays up until taken
  always @(negedge clk) begin
    if (!offer_live) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid        = 1'b1;
        in_ch.data_byte    = pending_bytes[0].data;
        in_ch.buffer_start = pending_bytes[0].start;
        offer_live         = 1'b1;
      end else begin
        in_ch.valid = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      decode_lpcm_byte(in_ch.data_byte, in_ch.buffer_start);
      void'(pending_bytes.pop_front());
      offer_live = 1'b0;
      bytes_taken++;
    end
  end

  // sample sink with random stalls and requested long hold-offs
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_samples
    sample_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_samples.size() == 0) begin
        log_error($sformatf("unexpected sample %0d chan %0d fend %0b last %0b",
                            out_ch.sample_out, out_ch.channel_index,
                            out_ch.frame_end, out_ch.run_last));
      end else begin
        want = expected_samples.pop_front();
        samples_checked++;
        if (out_ch.sample_out !== want.sample || out_ch.channel_index !== want.chan ||
            out_ch.frame_end !== want.fend || out_ch.run_last !== want.last) begin
          log_error($sformatf({"sample mismatch: expected %0d/ch%0d/fend%0b/last%0b",
                               " got %0d/ch%0d/fend%0b/last%0b"},
                              want.sample, want.chan, want.fend, want.last,
                              out_ch.sample_out, out_ch.channel_index,
                              out_ch.frame_end, out_ch.run_last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic start);
    lpcm_byte_t item;
    item.data  = data;
    item.start = start;
    pending_bytes.push_back(item);
    bytes_queued++;
    wait (bytes_taken == bytes_queued);
  endtask

  task automatic wait_drained();
    wait (bytes_taken == bytes_queued && samples_checked == samples_predicted);
  endtask

  // wait until all results are in and anything still in the pipe has settled
  task automatic go_quiet();
    wait_drained();
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lpcm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lpcm_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(posedge clk);
    case (idx)
      lpcm_pkg::CFG_SAMPLE_SIZE:   size_q   = value[1:0];
      lpcm_pkg::CFG_BYTE_ORDER:    endian_q = value[0];
      lpcm_pkg::CFG_CHANNEL_COUNT: chans_q  = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_format(input logic [1:0] size, input logic order, input logic [3:0] chans);
    go_quiet();
    write_reg(lpcm_pkg::CFG_SAMPLE_SIZE, lpcm_pkg::CFG_DATA_W'(size));
    write_reg(lpcm_pkg::CFG_BYTE_ORDER, lpcm_pkg::CFG_DATA_W'(order));
    write_reg(lpcm_pkg::CFG_CHANNEL_COUNT, chans);
  endtask

  function automatic logic [7:0] random_payload_byte();
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0:       return 8'h00;
        1:       return 8'h7f;
        2:       return 8'h80;
        default: return 8'hff;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  // reset format: 16 bits, big-endian, two channels
  task automatic test_reset_format();
    send_byte(8'h7f, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_sample_sizes();
    set_format(lpcm_pkg::SIZE_16, ORDER_LITTLE, 4'd1);
    send_byte(8'h34, 1'b0);
    send_byte(8'h12, 1'b0);
    // full scale positive clamps, full scale negative stays
    set_format(SIZE_24, ORDER_BIG, 4'd8);
    send_byte(8'h7f, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    set_format(SIZE_24, ORDER_LITTLE, 4'd8);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    // first sample of the pair rounds up past full scale
    set_format(lpcm_pkg::SIZE_20, ORDER_BIG, 4'd0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hf8, 1'b0);
    set_format(lpcm_pkg::SIZE_20, ORDER_LITTLE, 4'd15);
    send_byte(8'hff, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h8f, 1'b0);
    set_format(SIZE_RESERVED, ORDER_BIG, 4'd9);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  task automatic test_mid_sample_changes();
    set_format(lpcm_pkg::SIZE_20, ORDER_BIG, 4'd8);
    send_byte(8'h12, 1'b1);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    // phase already past the 16-bit end: next byte closes the sample
    go_quiet();
    write_reg(lpcm_pkg::CFG_SAMPLE_SIZE, lpcm_pkg::CFG_DATA_W'(lpcm_pkg::SIZE_16));
    send_byte(8'h78, 1'b0);
    send_byte(8'h9a, 1'b0);
    send_byte(8'hbc, 1'b0);
    send_byte(8'hde, 1'b0);
    send_byte(8'hf0, 1'b0);
    // counter now past the new last channel
    go_quiet();
    write_reg(lpcm_pkg::CFG_CHANNEL_COUNT, 4'd2);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    go_quiet();
    write_reg(lpcm_pkg::CFG_SAMPLE_SIZE, lpcm_pkg::CFG_DATA_W'(lpcm_pkg::SIZE_20));
    send_byte(8'hc0, 1'b0);
    send_byte(8'hde, 1'b0);
    send_byte(8'h55, 1'b0);
    go_quiet();
    write_reg(lpcm_pkg::CFG_SAMPLE_SIZE, lpcm_pkg::CFG_DATA_W'(SIZE_24));
    send_byte(8'haa, 1'b0);
  endtask

  task automatic test_buffer_restart();
    set_format(lpcm_pkg::SIZE_16, ORDER_BIG, 4'd3);
    send_byte(8'h11, 1'b1);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    // restart mid-sample and mid-frame
    send_byte(8'h44, 1'b1);
    send_byte(8'h55, 1'b0);
  endtask

  task automatic test_output_stall();
    int i;
    set_format(lpcm_pkg::SIZE_16, ORDER_LITTLE, 4'd4);
    hold_request = 64;
    for (i = 0; i < 40; i++) begin
      send_byte(random_payload_byte(), 1'b0);
    end
    wait_drained();
    set_format(lpcm_pkg::SIZE_20, ORDER_BIG, 4'd3);
    hold_request = 48;
    for (i = 0; i < 25; i++) begin
      send_byte(random_payload_byte(), 1'b0);
    end
    wait_drained();
  endtask

  task automatic test_random_stream(input int n_bytes);
    int sent;
    int n_samples;
    int width;
    int i;
    int k;
    logic [1:0] size;
    sent = 0;
    while (sent < n_bytes) begin
      size = 2'($urandom_range(3));
      set_format(size, 1'($urandom_range(1)), 4'($urandom_range(15)));
      width = (size == lpcm_pkg::SIZE_16) ? 2 : (size == lpcm_pkg::SIZE_20) ? 5 : 3;
      n_samples = $urandom_range(1, 10);
      for (i = 0; i < n_samples; i++) begin
        for (k = 0; k < width; k++) begin
          send_byte(random_payload_byte(), (i == 0 && k == 0 && $urandom_range(3) == 0));
          sent++;
        end
      end
      // broken tail: partial sample, sometimes with a restart
      if ($urandom_range(5) == 0) begin
        for (k = $urandom_range(1, 3); k > 0; k--) begin
          send_byte(random_payload_byte(), ($urandom_range(3) == 0));
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = lpcm_pkg::CFG_SAMPLE_SIZE;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = 8'h00;
    in_ch.buffer_start = 1'b0;
    out_ch.ready       = 1'b0;
    size_q             = lpcm_pkg::SIZE_16;
    endian_q           = ORDER_BIG;
    chans_q            = 4'd2;
    phase_q            = 3'd0;
    chan_q             = 3'd0;
    for (int i = 0; i < 4; i++) begin
      held_q[i] = 8'h00;
    end
    send_idle_pct = 6;
    recv_idle_pct = 78;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_format();
    test_sample_sizes();
    test_mid_sample_changes();
    test_buffer_restart();
    test_output_stall();
    test_random_stream(210);

    send_idle_pct = 78;
    recv_idle_pct = 6;
    test_random_stream(210);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(210);

    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
